// ===== rtl/dda_pkg.sv =====
package dda_pkg;

  localparam int COORD_BITS    = 16;
  localparam int DEF_FRAC_BITS = 16;
  localparam int REG_W         = 13;
  localparam int ADDR_W        = 24;
  localparam int COLOR_W       = 32;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd800;
  localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd600;

  // Command codes carried in the command field.
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Register indexes, taken from the word address.
  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  typedef struct packed {
    logic                          command;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  end_y;
    logic        [COLOR_W-1:0]     pen_color;
  } dda_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  pixel_x;
    logic signed [COORD_BITS-1:0]  pixel_y;
    logic        [ADDR_W-1:0]      pixel_address;
    logic                          write_enable;
    logic        [COLOR_W-1:0]     pixel_color;
    logic                          last_pixel;
  } dda_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PIX
  } dda_state_t;

  // Commands from the sequencer to the pixel stepper.
  typedef struct packed {
    logic load_line;
    logic load_steps;
    logic advance;
  } dda_step_cmd_t;

  // Launch of one serial increment divider.
  typedef struct packed {
    logic                  load;
    logic                  neg;
    logic [COORD_BITS-1:0] mag;
    logic [COORD_BITS-1:0] span;
  } dda_div_cmd_t;

endpackage

// ===== rtl/dda_divider.sv =====
module dda_divider #(
  parameter int FRAC_BITS = dda_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dda_pkg::dda_div_cmd_t       cmd_i,
  output logic                        done_o,
  output logic signed [FRAC_BITS+1:0] step_o
);
  import dda_pkg::*;

  localparam int MAG_W = COORD_BITS;
  localparam int Q_W   = FRAC_BITS + 2;
  localparam int ITER  = FRAC_BITS + 2;
  localparam int CNT_W = $clog2(ITER + 1);

  logic             busy_r;
  logic             done_r;
  logic             first_r;
  logic             neg_r;
  logic             zero_r;
  logic [MAG_W-1:0] rem_r;
  logic [MAG_W-1:0] rem_nxt;
  logic [MAG_W-1:0] span_r;
  logic [Q_W-1:0]   quo_r;
  logic [CNT_W-1:0] cnt_r;

  logic [MAG_W:0]   trial;
  logic [MAG_W:0]   diff;
  logic             qbit;
  logic [Q_W:0]     rounded;
  logic [Q_W-1:0]   mag_q;

  // One quotient bit per cycle. The first bit is the integer bit and uses the
  // remainder unshifted, since the magnitude may equal the span.
  always_comb begin
    trial   = first_r ? {1'b0, rem_r} : {rem_r, 1'b0};
    diff    = trial - {1'b0, span_r};
    qbit    = (trial >= {1'b0, span_r});
    rem_nxt = qbit ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
    // The quotient holds one extra fraction bit; adding one and dropping it
    // rounds half away from zero on the magnitude.
    rounded = {1'b0, quo_r} + (Q_W+1)'(1);
    mag_q   = rounded[Q_W:1];
    if (zero_r) begin
      step_o = '0;
    end else if (neg_r) begin
      step_o = -$signed(mag_q);
    end else begin
      step_o = $signed(mag_q);
    end
  end

  assign done_o = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd_i.load) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ITER);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      rem_r   <= cmd_i.mag;
      span_r  <= cmd_i.span;
      neg_r   <= cmd_i.neg;
      zero_r  <= (cmd_i.span == '0);
      first_r <= 1'b1;
      quo_r   <= '0;
    end else if (busy_r) begin
      rem_r   <= rem_nxt;
      first_r <= 1'b0;
      quo_r   <= {quo_r[Q_W-2:0], qbit};
    end
  end

  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !first_r && !zero_r |-> rem_r < span_r)
    else $error("divider remainder reached the span");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && !zero_r |-> mag_q <= (Q_W'(1) << FRAC_BITS))
    else $error("increment magnitude above one pixel");

endmodule

// ===== rtl/dda_stepper.sv =====
module dda_stepper #(
  parameter int FRAC_BITS = dda_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dda_pkg::dda_step_cmd_t             cmd_i,
  input  dda_pkg::dda_in_t                   line_i,
  input  logic [dda_pkg::COORD_BITS-1:0]     span_i,
  input  logic signed [FRAC_BITS+1:0]        step_x_i,
  input  logic signed [FRAC_BITS+1:0]        step_y_i,
  input  logic [dda_pkg::REG_W-1:0]          width_i,
  input  logic [dda_pkg::REG_W-1:0]          height_i,
  output logic                               has_pixels_o,
  output dda_pkg::dda_out_t                  result_o
);
  import dda_pkg::*;

  localparam int STEP_W = FRAC_BITS + 2;
  localparam int POS_W  = COORD_BITS + 1 + FRAC_BITS;
  localparam int RND_W  = POS_W + 1 - FRAC_BITS;
  localparam int LEFT_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * REG_W + 1;

  localparam logic [POS_W-1:0] HALF =
    {{(POS_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  logic signed [POS_W-1:0]  pos_x_r;
  logic signed [POS_W-1:0]  pos_y_r;
  logic signed [STEP_W-1:0] step_x_r;
  logic signed [STEP_W-1:0] step_y_r;
  logic [LEFT_W-1:0]        left_r;
  logic [COLOR_W-1:0]       color_r;
  logic signed [RND_W-1:0]  px_r;
  logic signed [RND_W-1:0]  py_r;
  logic                     inside_r;
  logic                     last_r;

  logic signed [RND_W-1:0]  rx;
  logic signed [RND_W-1:0]  ry;
  logic                     in_screen;
  logic [PROD_W-1:0]        addr_sum;

  // Round to nearest, halves away from zero: a negative value takes one less
  // than half before the floor.
  function automatic logic signed [RND_W-1:0] round_pos(input logic [POS_W-1:0] p);
    logic [POS_W:0] s;
    begin
      s = {p[POS_W-1], p} + {1'b0, HALF} - {{POS_W{1'b0}}, p[POS_W-1]};
      return s[POS_W:FRAC_BITS];
    end
  endfunction

  always_comb begin
    rx = round_pos(pos_x_r);
    ry = round_pos(pos_y_r);
    in_screen = !rx[RND_W-1] && ($unsigned(rx) < {{(RND_W-REG_W){1'b0}}, width_i}) &&
                !ry[RND_W-1] && ($unsigned(ry) < {{(RND_W-REG_W){1'b0}}, height_i});
  end

  // The address stage of a pixel forms the frame-buffer address. Inside the
  // screen both coordinates fit the register width.
  always_comb begin
    addr_sum = PROD_W'(py_r[REG_W-1:0]) * PROD_W'(width_i) + PROD_W'(px_r[REG_W-1:0]);
    result_o.pixel_x       = px_r[COORD_BITS-1:0];
    result_o.pixel_y       = py_r[COORD_BITS-1:0];
    result_o.pixel_address = inside_r ? addr_sum[ADDR_W-1:0] : '0;
    result_o.write_enable  = inside_r;
    result_o.pixel_color   = color_r;
    result_o.last_pixel    = last_r;
  end

  assign has_pixels_o = (left_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (cmd_i.load_line) begin
      left_r <= {1'b0, span_i} + LEFT_W'(1);
    end else if (cmd_i.advance) begin
      left_r <= left_r - LEFT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_line) begin
      pos_x_r <= {line_i.start_x[COORD_BITS-1], line_i.start_x, {FRAC_BITS{1'b0}}};
      pos_y_r <= {line_i.start_y[COORD_BITS-1], line_i.start_y, {FRAC_BITS{1'b0}}};
      color_r <= line_i.pen_color;
    end else if (cmd_i.advance) begin
      pos_x_r  <= pos_x_r + POS_W'(step_x_r);
      pos_y_r  <= pos_y_r + POS_W'(step_y_r);
      px_r     <= rx;
      py_r     <= ry;
      inside_r <= in_screen;
      last_r   <= (left_r == LEFT_W'(1));
    end
    if (cmd_i.load_steps) begin
      step_x_r <= step_x_i;
      step_y_r <= step_y_i;
    end
  end

  a_advance_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.advance |-> left_r != '0)
    else $error("advance issued with no pixels left");

  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.load_line |=> left_r != '0)
    else $error("new line loaded with an empty pixel count");

endmodule

// ===== rtl/dda_line_rasterizer_top.sv =====
// Channel  | Valid     | Stall     | Payload             | Beat taken when
// ---------+-----------+-----------+---------------------+-------------------------------
// input    | in_valid  | in_stall  | in_data  (dda_in_t) | in_valid high, in_stall low
// output   | out_valid | out_stall | out_data (dda_out_t)| out_valid high, out_stall low
// config   | psel      | pready    | paddr/pwdata/prdata | psel, penable, pwrite, pready
//
// A start beat launches the two axis dividers, which each produce one
// quotient bit per cycle; the increments are then loaded into the stepper.
// An advance beat that yields a pixel is rounded and clipped first, then the
// row times width multiply-add forms the address in the address stage.
// An advance beat with no pixels left yields nothing.
// Reset (rst_n low, synchronous) empties the line and restores the screen
// size to 800 by 600. A stalled output holds its beat while the next input
// beat is taken; a second pixel then waits in the address stage.
module dda_line_rasterizer_top #(
  parameter int FRAC_BITS = dda_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dda_pkg::dda_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dda_pkg::dda_out_t               out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dda_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [dda_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [dda_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import dda_pkg::*;

  localparam int STEP_W = FRAC_BITS + 2;
  localparam int DIFF_W = COORD_BITS + 1;

  dda_state_t          state_r;
  dda_state_t          state_nxt;
  logic [REG_W-1:0]    width_r;
  logic [REG_W-1:0]    height_r;
  logic                out_valid_r;
  dda_out_t            out_data_r;

  logic                in_accept;
  logic                start_beat;
  logic                load_out;
  logic                cfg_write;
  logic                cfg_idx;

  logic [DIFF_W-1:0]     dx;
  logic [DIFF_W-1:0]     dy;
  logic [DIFF_W-1:0]     ax_full;
  logic [DIFF_W-1:0]     ay_full;
  logic [COORD_BITS-1:0] ax;
  logic [COORD_BITS-1:0] ay;
  logic [COORD_BITS-1:0] span;

  dda_div_cmd_t          div_x_cmd;
  dda_div_cmd_t          div_y_cmd;
  logic                  div_x_done;
  logic                  div_y_done;
  logic signed [STEP_W-1:0] step_x;
  logic signed [STEP_W-1:0] step_y;

  dda_step_cmd_t         step_cmd;
  logic                  has_pixels;
  dda_out_t              result;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign start_beat = in_accept && (in_data.command == CMD_START);

  // Deltas are one bit wider than the coordinates; their magnitudes fit the
  // coordinate width again, and the larger one is the span.
  always_comb begin
    dx      = {in_data.end_x[COORD_BITS-1], in_data.end_x} -
              {in_data.start_x[COORD_BITS-1], in_data.start_x};
    dy      = {in_data.end_y[COORD_BITS-1], in_data.end_y} -
              {in_data.start_y[COORD_BITS-1], in_data.start_y};
    ax_full = dx[DIFF_W-1] ? -dx : dx;
    ay_full = dy[DIFF_W-1] ? -dy : dy;
    ax      = ax_full[COORD_BITS-1:0];
    ay      = ay_full[COORD_BITS-1:0];
    span    = (ax >= ay) ? ax : ay;

    div_x_cmd.load = start_beat;
    div_x_cmd.neg  = dx[DIFF_W-1];
    div_x_cmd.mag  = ax;
    div_x_cmd.span = span;
    div_y_cmd.load = start_beat;
    div_y_cmd.neg  = dy[DIFF_W-1];
    div_y_cmd.mag  = ay;
    div_y_cmd.span = span;
  end

  dda_divider #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd_i  (div_x_cmd),
    .done_o (div_x_done),
    .step_o (step_x)
  );

  dda_divider #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd_i  (div_y_cmd),
    .done_o (div_y_done),
    .step_o (step_y)
  );

  dda_stepper #(.FRAC_BITS(FRAC_BITS)) u_stepper (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_i        (step_cmd),
    .line_i       (in_data),
    .span_i       (span),
    .step_x_i     (step_x),
    .step_y_i     (step_y),
    .width_i      (width_r),
    .height_i     (height_r),
    .has_pixels_o (has_pixels),
    .result_o     (result)
  );

  // Sequencer. A start launches both dividers and waits for the increments;
  // an advance with pixels left goes through the address stage, which hands
  // its pixel to the output register as soon as that register is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_cmd  = '0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data.command == CMD_START) begin
            step_cmd.load_line = 1'b1;
            state_nxt          = ST_DIV;
          end else if (has_pixels) begin
            step_cmd.advance = 1'b1;
            state_nxt        = ST_PIX;
          end
        end
      end
      ST_DIV: begin
        if (div_x_done && div_y_done) begin
          step_cmd.load_steps = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      ST_PIX: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: it holds a finished pixel so that the input side can
  // go on while the consumer stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Register port. The word address picks the register; reads are always
  // available with no wait states.
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[CFG_ADDR_W-1];
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_IDX_WIDTH:  width_r  <= pwdata[REG_W-1:0];
        REG_IDX_HEIGHT: height_r <= pwdata[REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IDX_WIDTH:  prdata = {{(CFG_DATA_W-REG_W){1'b0}}, width_r};
      REG_IDX_HEIGHT: prdata = {{(CFG_DATA_W-REG_W){1'b0}}, height_r};
      default:        prdata = '0;
    endcase
  end

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start_beat |=> in_stall)
    else $error("start beat did not hold off the input while dividing");

  a_clipped_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.write_enable |-> out_data.pixel_address == '0)
    else $error("clipped pixel carries a nonzero address");

endmodule
